// ----- sv/lpf4_pkg.sv -----
// Shared constants, types and command codes for the four-pole ladder filter.
package lpf4_pkg;

    localparam int STATE_FRAC_BITS = 24;   // Q8.24 filter state
    localparam int COEF_FRAC_BITS  = 14;   // Q3.14 coefficients
    localparam int SAMPLE_W        = 16;
    localparam int STATE_W         = 32;
    localparam int COEF_W          = 17;
    localparam int MODE_W          = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int MUL_W           = STATE_W + 1;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int IN_SHIFT        = STATE_FRAC_BITS - (SAMPLE_W - 1);
    localparam int SIXTH_FRAC      = 20;
    localparam int SIXTH_Q20       = 174763;  // 1/6 in Q0.20

    // stage register indices
    localparam logic [1:0] STG_ONE   = 2'd0;
    localparam logic [1:0] STG_TWO   = 2'd1;
    localparam logic [1:0] STG_THREE = 2'd2;
    localparam logic [1:0] STG_FOUR  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_MODE,
        REG_COEF_P,
        REG_COEF_F,
        REG_COEF_Q
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOWPASS,
        MODE_BANDPASS,
        MODE_HIGHPASS
    } mode_t;

    // multiplier operand A source
    typedef enum logic [3:0] {
        OPA_FB_SUM,
        OPA_S1_SUM,
        OPA_S2_SUM,
        OPA_S3_SUM,
        OPA_S1,
        OPA_S2,
        OPA_S3,
        OPA_S4,
        OPA_SQ,
        OPA_CLO,
        OPA_CHI
    } opa_t;

    // multiplier operand B source
    typedef enum logic [2:0] {
        OPB_P,
        OPB_F,
        OPB_Q,
        OPB_S4,
        OPB_SIXTH
    } opb_t;

    // what happens to the product registered in the previous cycle
    typedef enum logic [2:0] {
        POST_NONE,
        POST_FB,
        POST_LOAD,
        POST_FIN,
        POST_SQ,
        POST_CUBE,
        POST_TERM
    } post_t;

    typedef struct packed {
        logic                      enable;
        logic [MODE_W-1:0]         mode;
        logic signed [COEF_W-1:0]  coef_p;
        logic signed [COEF_W-1:0]  coef_f;
        logic signed [COEF_W-1:0]  coef_q;
    } cfg_t;

    typedef struct packed {
        logic       load_sample;
        opa_t       opa;
        opb_t       opb;
        post_t      post;
        logic [1:0] dst;
        logic       out_write;
        logic       bypass;
    } cmd_t;

endpackage

// ----- sv/lpf4_cfg.sv -----
// Configuration register bank for the ladder filter.
module lpf4_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lpf4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpf4_pkg::COEF_W-1:0]       cfg_data,
    output lpf4_pkg::cfg_t                    cfg
);

    lpf4_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (lpf4_pkg::cfg_reg_t'(cfg_index))
                lpf4_pkg::REG_ENABLE: cfg_reg.enable <= cfg_data[0];
                lpf4_pkg::REG_MODE:   cfg_reg.mode   <= cfg_data[lpf4_pkg::MODE_W-1:0];
                lpf4_pkg::REG_COEF_P: cfg_reg.coef_p <= cfg_data;
                lpf4_pkg::REG_COEF_F: cfg_reg.coef_f <= cfg_data;
                lpf4_pkg::REG_COEF_Q: cfg_reg.coef_q <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/lpf4_dp.sv -----
// Datapath: shared 33x33 multiplier, accumulator, filter state and output stage.
module lpf4_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lpf4_pkg::cfg_t                       cfg,
    input  lpf4_pkg::cmd_t                       cmd,
    input  logic signed [lpf4_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [lpf4_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 saturated
);

    localparam int PW    = lpf4_pkg::PROD_W;
    localparam int MW    = lpf4_pkg::MUL_W;
    localparam int SW    = lpf4_pkg::STATE_W;
    localparam int TAP_W = lpf4_pkg::STATE_W + 4;
    localparam int OW    = lpf4_pkg::SAMPLE_W;

    localparam logic signed [PW-1:0] COEF_HALF  = PW'(1) <<< (lpf4_pkg::COEF_FRAC_BITS - 1);
    localparam logic signed [PW-1:0] STATE_HALF = PW'(1) <<< (lpf4_pkg::STATE_FRAC_BITS - 1);
    localparam logic signed [PW-1:0] SIXTH_HALF = PW'(1) <<< (lpf4_pkg::SIXTH_FRAC - 1);
    localparam logic signed [PW-1:0] S32_MAX    = (PW'(1) <<< (SW - 1)) - PW'(1);
    localparam logic signed [PW-1:0] S32_MIN    = -(PW'(1) <<< (SW - 1));
    localparam logic signed [TAP_W-1:0] TAP_HALF = TAP_W'(1) <<< (lpf4_pkg::IN_SHIFT - 1);
    localparam logic signed [TAP_W-1:0] OUT_MAX  = (TAP_W'(1) <<< (OW - 1)) - TAP_W'(1);
    localparam logic signed [TAP_W-1:0] OUT_MIN  = -(TAP_W'(1) <<< (OW - 1));

    function automatic logic signed [SW-1:0] sat32(input logic signed [PW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > S32_MAX)
            r = S32_MAX[SW-1:0];
        else if (v < S32_MIN)
            r = S32_MIN[SW-1:0];
        else
            r = v[SW-1:0];
        return r;
    endfunction

    logic signed [OW-1:0] sample_reg;
    logic signed [SW-1:0] fb_reg;
    logic signed [SW-1:0] last_reg;
    logic signed [SW-1:0] tmp_reg;
    logic signed [SW-1:0] s_reg [4];
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [OW-1:0] out_reg;
    logic                 sat_reg;

    logic signed [MW-1:0] op_a;
    logic signed [MW-1:0] op_b;
    logic signed [PW-1:0] prod_next;

    logic signed [PW-1:0] x_ext;
    logic signed [SW-1:0] fb_val;
    logic signed [SW-1:0] fin_val;
    logic signed [PW-1:0] sq_raw;
    logic signed [PW-1:0] sq_val;
    logic signed [PW-1:0] term;
    logic signed [SW-1:0] s4_clip;

    logic signed [TAP_W-1:0] diff;
    logic signed [TAP_W-1:0] band;
    logic signed [TAP_W-1:0] tap;
    logic signed [TAP_W-1:0] tap_rnd;
    logic signed [OW-1:0]    out_val;
    logic                    out_sat;

    // operand selection
    always_comb
    begin
        case (cmd.opa)
            lpf4_pkg::OPA_FB_SUM: op_a = MW'(fb_reg) + MW'(last_reg);
            lpf4_pkg::OPA_S1_SUM: op_a = MW'(s_reg[lpf4_pkg::STG_ONE]) + MW'(tmp_reg);
            lpf4_pkg::OPA_S2_SUM: op_a = MW'(s_reg[lpf4_pkg::STG_TWO]) + MW'(tmp_reg);
            lpf4_pkg::OPA_S3_SUM: op_a = MW'(s_reg[lpf4_pkg::STG_THREE]) + MW'(tmp_reg);
            lpf4_pkg::OPA_S1:     op_a = MW'(s_reg[lpf4_pkg::STG_ONE]);
            lpf4_pkg::OPA_S2:     op_a = MW'(s_reg[lpf4_pkg::STG_TWO]);
            lpf4_pkg::OPA_S3:     op_a = MW'(s_reg[lpf4_pkg::STG_THREE]);
            lpf4_pkg::OPA_SQ:     op_a = acc_reg[MW-1:0];
            lpf4_pkg::OPA_CLO:    op_a = {{(MW - lpf4_pkg::SIXTH_FRAC){1'b0}},
                                          acc_reg[lpf4_pkg::SIXTH_FRAC-1:0]};
            lpf4_pkg::OPA_CHI:    op_a = MW'(acc_reg >>> lpf4_pkg::SIXTH_FRAC);
            default:              op_a = MW'(s_reg[lpf4_pkg::STG_FOUR]);
        endcase

        case (cmd.opb)
            lpf4_pkg::OPB_P:     op_b = MW'(cfg.coef_p);
            lpf4_pkg::OPB_F:     op_b = MW'(cfg.coef_f);
            lpf4_pkg::OPB_Q:     op_b = MW'(cfg.coef_q);
            lpf4_pkg::OPB_SIXTH: op_b = MW'(lpf4_pkg::SIXTH_Q20);
            default:             op_b = MW'(s_reg[lpf4_pkg::STG_FOUR]);
        endcase
    end

    assign prod_next = PW'(op_a) * PW'(op_b);

    // post-processing of the previous product
    assign x_ext   = PW'(sample_reg) <<< lpf4_pkg::IN_SHIFT;
    assign fb_val  = sat32(x_ext - ((prod_reg + COEF_HALF) >>> lpf4_pkg::COEF_FRAC_BITS));
    assign fin_val = sat32((prod_reg - acc_reg + COEF_HALF) >>> lpf4_pkg::COEF_FRAC_BITS);
    assign sq_raw  = (prod_reg + STATE_HALF) >>> lpf4_pkg::STATE_FRAC_BITS;
    assign sq_val  = (sq_raw > S32_MAX) ? S32_MAX : sq_raw;
    assign term    = (acc_reg + (prod_reg <<< lpf4_pkg::SIXTH_FRAC) + SIXTH_HALF)
                     >>> lpf4_pkg::SIXTH_FRAC;
    assign s4_clip = sat32(PW'(s_reg[lpf4_pkg::STG_FOUR]) - term);

    // output tap
    always_comb
    begin
        diff = TAP_W'(s_reg[lpf4_pkg::STG_THREE]) - TAP_W'(s_reg[lpf4_pkg::STG_FOUR]);
        band = (diff <<< 1) + diff;
        case (lpf4_pkg::mode_t'(cfg.mode))
            lpf4_pkg::MODE_BANDPASS: tap = band;
            lpf4_pkg::MODE_HIGHPASS: tap = TAP_W'(fb_reg) - band
                                           - TAP_W'(s_reg[lpf4_pkg::STG_FOUR]);
            default:                 tap = TAP_W'(s_reg[lpf4_pkg::STG_FOUR]);
        endcase
        tap_rnd = (tap + TAP_HALF) >>> lpf4_pkg::IN_SHIFT;
        if (tap_rnd > OUT_MAX)
        begin
            out_val = OUT_MAX[OW-1:0];
            out_sat = 1'b1;
        end
        else if (tap_rnd < OUT_MIN)
        begin
            out_val = OUT_MIN[OW-1:0];
            out_sat = 1'b1;
        end
        else
        begin
            out_val = tap_rnd[OW-1:0];
            out_sat = 1'b0;
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.post == lpf4_pkg::POST_FIN)
                s_reg[cmd.dst] <= fin_val;
            else if (cmd.post == lpf4_pkg::POST_TERM)
                s_reg[lpf4_pkg::STG_FOUR] <= s4_clip;
            if (cmd.out_write && !cmd.bypass)
                last_reg <= fb_reg;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load_sample)
            sample_reg <= sample_in;
        case (cmd.post)
            lpf4_pkg::POST_FB:   fb_reg  <= fb_val;
            lpf4_pkg::POST_LOAD: acc_reg <= prod_reg;
            lpf4_pkg::POST_FIN:  tmp_reg <= s_reg[cmd.dst];
            lpf4_pkg::POST_SQ:   acc_reg <= sq_val;
            lpf4_pkg::POST_CUBE: acc_reg <= sq_raw;
            default:             ;
        endcase
        if (cmd.out_write)
        begin
            out_reg <= cmd.bypass ? sample_reg : out_val;
            sat_reg <= cmd.bypass ? 1'b0 : out_sat;
        end
    end

    assign sample_out = out_reg;
    assign saturated  = sat_reg;

endmodule

// ----- sv/lpf4_ctrl.sv -----
// Sequencer: steps one sample through the shared multiplier schedule.
module lpf4_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           enable,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output lpf4_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_QS4,
        ST_FB,
        ST_S1P,
        ST_S1F,
        ST_S2P,
        ST_S2F,
        ST_S3P,
        ST_S3F,
        ST_S4P,
        ST_S4FIN,
        ST_SQR,
        ST_SQ,
        ST_CUBE,
        ST_CUBEFIN,
        ST_CLO,
        ST_CHI,
        ST_TERM,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   bypass_reg, bypass_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        bypass_next     = bypass_reg;
        cmd.load_sample = 1'b0;
        cmd.opa         = lpf4_pkg::OPA_S4;
        cmd.opb         = lpf4_pkg::OPB_S4;
        cmd.post        = lpf4_pkg::POST_NONE;
        cmd.dst         = lpf4_pkg::STG_ONE;
        cmd.out_write   = 1'b0;
        cmd.bypass      = bypass_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    bypass_next     = !enable;
                    state_next      = enable ? ST_QS4 : ST_OUT;
                end
            end
            ST_QS4:
            begin
                cmd.opb    = lpf4_pkg::OPB_Q;
                state_next = ST_FB;
            end
            ST_FB:
            begin
                cmd.opa    = lpf4_pkg::OPA_S1;
                cmd.opb    = lpf4_pkg::OPB_F;
                cmd.post   = lpf4_pkg::POST_FB;
                state_next = ST_S1P;
            end
            ST_S1P:
            begin
                cmd.opa    = lpf4_pkg::OPA_FB_SUM;
                cmd.opb    = lpf4_pkg::OPB_P;
                cmd.post   = lpf4_pkg::POST_LOAD;
                state_next = ST_S1F;
            end
            ST_S1F:
            begin
                cmd.opa    = lpf4_pkg::OPA_S2;
                cmd.opb    = lpf4_pkg::OPB_F;
                cmd.post   = lpf4_pkg::POST_FIN;
                cmd.dst    = lpf4_pkg::STG_ONE;
                state_next = ST_S2P;
            end
            ST_S2P:
            begin
                cmd.opa    = lpf4_pkg::OPA_S1_SUM;
                cmd.opb    = lpf4_pkg::OPB_P;
                cmd.post   = lpf4_pkg::POST_LOAD;
                state_next = ST_S2F;
            end
            ST_S2F:
            begin
                cmd.opa    = lpf4_pkg::OPA_S3;
                cmd.opb    = lpf4_pkg::OPB_F;
                cmd.post   = lpf4_pkg::POST_FIN;
                cmd.dst    = lpf4_pkg::STG_TWO;
                state_next = ST_S3P;
            end
            ST_S3P:
            begin
                cmd.opa    = lpf4_pkg::OPA_S2_SUM;
                cmd.opb    = lpf4_pkg::OPB_P;
                cmd.post   = lpf4_pkg::POST_LOAD;
                state_next = ST_S3F;
            end
            ST_S3F:
            begin
                cmd.opa    = lpf4_pkg::OPA_S4;
                cmd.opb    = lpf4_pkg::OPB_F;
                cmd.post   = lpf4_pkg::POST_FIN;
                cmd.dst    = lpf4_pkg::STG_THREE;
                state_next = ST_S4P;
            end
            ST_S4P:
            begin
                cmd.opa    = lpf4_pkg::OPA_S3_SUM;
                cmd.opb    = lpf4_pkg::OPB_P;
                cmd.post   = lpf4_pkg::POST_LOAD;
                state_next = ST_S4FIN;
            end
            ST_S4FIN:
            begin
                cmd.post   = lpf4_pkg::POST_FIN;
                cmd.dst    = lpf4_pkg::STG_FOUR;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.post   = lpf4_pkg::POST_SQ;
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                cmd.opa    = lpf4_pkg::OPA_SQ;
                state_next = ST_CUBEFIN;
            end
            ST_CUBEFIN:
            begin
                cmd.post   = lpf4_pkg::POST_CUBE;
                state_next = ST_CLO;
            end
            ST_CLO:
            begin
                cmd.opa    = lpf4_pkg::OPA_CLO;
                cmd.opb    = lpf4_pkg::OPB_SIXTH;
                state_next = ST_CHI;
            end
            ST_CHI:
            begin
                cmd.opa    = lpf4_pkg::OPA_CHI;
                cmd.opb    = lpf4_pkg::OPB_SIXTH;
                cmd.post   = lpf4_pkg::POST_LOAD;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                cmd.post   = lpf4_pkg::POST_TERM;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_write = out_free;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_write)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bypass_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bypass_reg    <= bypass_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- sv/ladder_lowpass_filter_4pole.sv -----
// Top level of the four-pole ladder low-pass filter with selectable tap.
//
//  channel  | direction | payload                        | transfer when
//  ---------+-----------+--------------------------------+---------------------------
//  s_axis   | in        | tdata[15:0] sample_in          | s_axis_tvalid & tready
//  m_axis   | out       | tdata[15:0] sample_out,        | m_axis_tvalid & tready
//           |           | tuser[0] saturated             |
//  cfg      | in        | cfg_index selects, cfg_data    | cfg_wr_en high
//
//  Filtered sample: after the input transfer the sequencer walks 18 steps, the last
//  of which writes the result into the output register; the schedule is set by one
//  shared 33x33 multiplier doing 13 products with a registered product. A bypass sample
//  skips to the output step. Input is taken again as soon as the sequencer is idle,
//  even while the previous result waits in the output register.
//  A stalled output holds the sequencer in its last step; nothing is dropped.
//  Reset (rst_n low, asynchronous) clears the configuration, the filter state and
//  the handshake; datapath working registers are always loaded before they are read.
module ladder_lowpass_filter_4pole (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lpf4_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [15:0] sample_in

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lpf4_pkg::SAMPLE_W-1:0]      m_axis_tdata,   // [15:0] sample_out
    output logic                               m_axis_tuser,   // [0] saturated

    input  logic                               cfg_wr_en,
    input  logic [lpf4_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpf4_pkg::COEF_W-1:0]        cfg_data
);

    lpf4_pkg::cfg_t cfg;
    lpf4_pkg::cmd_t cmd;

    logic signed [lpf4_pkg::SAMPLE_W-1:0] sample_out;

    // register bank: enable, tap select and the three Q3.14 gains
    lpf4_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: decides bypass at the input transfer, then walks the schedule
    lpf4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (cfg.enable),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // datapath: feedback, four one-pole stages, cubic soft clip, tap and rounding
    lpf4_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sample_in  (s_axis_tdata),
        .sample_out (sample_out),
        .saturated  (m_axis_tuser)
    );

    assign m_axis_tdata = sample_out;

endmodule

// ----- sim/ladder_lowpass_filter_4pole_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the four-pole ladder low-pass filter with selectable tap.
module ladder_lowpass_filter_4pole_tb;

    // Output mode 3 is not named in the package; the filter treats it as low-pass.
    localparam logic [lpf4_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;
    localparam int                CYCLE_LIMIT = 1000000;
    // Extra margin that wait_drain waits once every due sample has come out.
    localparam int                SETTLE_CYCLES = 30;
    localparam int                REPORT_MAX    = 30;
    localparam int                BLOCK_ITEMS   = 95;

    typedef struct packed {
        logic [lpf4_pkg::SAMPLE_W-1:0] sample;
        logic                          clip;
    } tap_out_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;

    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lpf4_pkg::SAMPLE_W-1:0]   s_axis_tdata = '0;     // [15:0] sample_in

    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lpf4_pkg::SAMPLE_W-1:0]   m_axis_tdata;          // [15:0] sample_out
    logic                            m_axis_tuser;          // [0] saturated

    logic                            cfg_wr_en = 1'b0;
    logic [lpf4_pkg::CFG_IDX_W-1:0]  cfg_index = lpf4_pkg::REG_ENABLE;
    logic [lpf4_pkg::COEF_W-1:0]     cfg_data = '0;

    // Predicted register file and filter state, all in plain 64-bit arithmetic.
    logic                            mdl_enable;
    logic [lpf4_pkg::MODE_W-1:0]     mdl_mode;
    longint                k_p, k_f, k_q;
    longint                prev_in, st1, st2, st3, st4;

    tap_out_t              due_samples[$];
    tap_out_t              due_head;

    int                    src_idle_pct  = 0;
    int                    sink_stall_pct = 0;
    int                    hold_left     = 0;
    int                    cycle_count   = 0;
    int                    fault_count   = 0;
    int                    samples_sent  = 0;
    int                    samples_checked = 0;
    int                    clip_count    = 0;
    int                    bypass_count  = 0;

    ladder_lowpass_filter_4pole dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a correct run finishes far inside this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples still due",
                     cycle_count, due_samples.size());
            $display("ladder_lowpass_filter_4pole_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers. Shifts round half up: add half, then floor.
    // ------------------------------------------------------------------
    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // One pole: (a + b) * p - old * f, back to Q8.24.
    function automatic longint pole(longint a, longint b, longint old);
        return sat32(rnd_shift((a + b) * k_p - old * k_f, lpf4_pkg::COEF_FRAC_BITS));
    endfunction

    // Advances the predicted filter by one sample and returns the tap it yields.
    function automatic tap_out_t ladder_predict(logic [lpf4_pkg::SAMPLE_W-1:0] din);
        tap_out_t res;
        longint   x, fb, t1, t2, sq, cube, term, tap, r;
        res.clip = 1'b0;
        if (!mdl_enable)
        begin
            res.sample = din;     // bypass leaves the state alone
            return res;
        end
        x  = longint'($signed(din)) * (longint'(1) << lpf4_pkg::IN_SHIFT);
        fb = sat32(x - rnd_shift(k_q * st4, lpf4_pkg::COEF_FRAC_BITS));

        t1  = st1;
        st1 = pole(fb, prev_in, st1);
        t2  = st2;
        st2 = pole(st1, t1, st2);
        t1  = st3;
        st3 = pole(st2, t2, st3);
        st4 = pole(st3, t1, st4);

        // soft clip y - y^3/6, square clamped before the cube
        sq = rnd_shift(st4 * st4, lpf4_pkg::STATE_FRAC_BITS);
        if (sq > 64'sd2147483647)
            sq = 64'sd2147483647;
        cube = rnd_shift(sq * st4, lpf4_pkg::STATE_FRAC_BITS);
        term = rnd_shift(cube * lpf4_pkg::SIXTH_Q20, lpf4_pkg::SIXTH_FRAC);
        st4  = sat32(st4 - term);
        prev_in = fb;

        if (mdl_mode == lpf4_pkg::MODE_BANDPASS)
            tap = 3 * (st3 - st4);
        else if (mdl_mode == lpf4_pkg::MODE_HIGHPASS)
            tap = fb - 3 * (st3 - st4) - st4;
        else
            tap = st4;            // low-pass, and the spare mode

        r = rnd_shift(tap, lpf4_pkg::STATE_FRAC_BITS - (lpf4_pkg::SAMPLE_W - 1));
        if (r > 32767)
        begin
            r = 32767;
            res.clip = 1'b1;
        end
        else if (r < -32768)
        begin
            r = -32768;
            res.clip = 1'b1;
        end
        res.sample = r[lpf4_pkg::SAMPLE_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_fault(input string what, input int want, input int got);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Output transfers are taken at the rising edge and matched in order.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_samples.size() == 0)
                report_fault("unexpected output transfer", 0, $signed(m_axis_tdata));
            else
            begin
                due_head = due_samples.pop_front();
                samples_checked++;
                if (due_head.clip)
                    clip_count++;
                if (m_axis_tdata !== due_head.sample)
                    report_fault("sample_out", $signed(due_head.sample),
                                 $signed(m_axis_tdata));
                if (m_axis_tuser !== due_head.clip)
                    report_fault("saturated", due_head.clip, m_axis_tuser);
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off when one is armed.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Driving tasks: inputs change on the falling edge only.
    // ------------------------------------------------------------------
    task automatic write_reg(input lpf4_pkg::cfg_reg_t idx,
                             input logic [lpf4_pkg::COEF_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            lpf4_pkg::REG_ENABLE: mdl_enable = val[0];
            lpf4_pkg::REG_MODE:   mdl_mode   = val[lpf4_pkg::MODE_W-1:0];
            lpf4_pkg::REG_COEF_P: k_p = longint'($signed(val));
            lpf4_pkg::REG_COEF_F: k_f = longint'($signed(val));
            lpf4_pkg::REG_COEF_Q: k_q = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic set_filter(input logic en, input logic [lpf4_pkg::MODE_W-1:0] mode,
                              input int p, input int f, input int q);
        write_reg(lpf4_pkg::REG_COEF_P, lpf4_pkg::COEF_W'(p));
        write_reg(lpf4_pkg::REG_COEF_F, lpf4_pkg::COEF_W'(f));
        write_reg(lpf4_pkg::REG_COEF_Q, lpf4_pkg::COEF_W'(q));
        write_reg(lpf4_pkg::REG_MODE, lpf4_pkg::COEF_W'(mode));
        write_reg(lpf4_pkg::REG_ENABLE, lpf4_pkg::COEF_W'(en));
    endtask

    // Offers one sample until the filter takes it, then books the expected tap.
    task automatic send_sample(input logic [lpf4_pkg::SAMPLE_W-1:0] s);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= lpf4_pkg::SAMPLE_W'($urandom);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do
            @(posedge clk);
        while (!s_axis_tready);
        due_samples.push_back(ladder_predict(s));
        samples_sent++;
        if (!mdl_enable)
            bypass_count++;
    endtask

    // Drops valid, waits for every due sample, then lets the sequencer settle
    // so that a register write never lands mid-computation.
    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (due_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [lpf4_pkg::SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return lpf4_pkg::SAMPLE_W'($urandom);
        if (sel < 80)
            return lpf4_pkg::SAMPLE_W'($urandom_range(4000) - 2000);
        if (sel < 90)
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        return lpf4_pkg::SAMPLE_W'($urandom_range(200) - 100);
    endfunction

    // Mostly usable cut-off settings (f = 2p - 1), sometimes anything at all.
    task automatic random_setting();
        int p, f, q;
        logic en;
        if ($urandom_range(3) != 0)
        begin
            p = $urandom_range(15000, 800);
            f = 2 * p - (1 << lpf4_pkg::COEF_FRAC_BITS);
            q = $urandom_range(65535);
        end
        else
        begin
            p = $urandom_range(131071);
            f = $urandom_range(131071);
            q = $urandom_range(131071);
        end
        en = ($urandom_range(7) != 0);
        set_filter(en, lpf4_pkg::MODE_W'($urandom_range(3)), p, f, q);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the filter is disabled: samples come back unchanged.
    task automatic test_bypass();
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        wait_drain();
        write_reg(lpf4_pkg::REG_ENABLE, lpf4_pkg::COEF_W'(0));
        send_sample(16'hAAAA);
        wait_drain();
    endtask

    // Full-scale steps through every tap, the spare mode included.
    task automatic test_taps();
        logic [lpf4_pkg::MODE_W-1:0] modes[4];
        modes = '{lpf4_pkg::MODE_LOWPASS, lpf4_pkg::MODE_BANDPASS,
                  lpf4_pkg::MODE_HIGHPASS, MODE_SPARE};
        set_filter(1'b1, lpf4_pkg::MODE_LOWPASS, 4915, -6554, 16384);
        foreach (modes[i])
        begin
            write_reg(lpf4_pkg::REG_MODE, lpf4_pkg::COEF_W'(modes[i]));
            send_sample(16'h7FFF);
            send_sample(16'h8000);
            send_sample(16'h7FFF);
            wait_drain();
        end
    endtask

    // Extreme coefficients drive the state into saturation and the square clamp.
    task automatic test_coef_extremes();
        set_filter(1'b1, lpf4_pkg::MODE_HIGHPASS, 65535, -65536, -65536);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        wait_drain();
        set_filter(1'b1, lpf4_pkg::MODE_LOWPASS, -65536, 65535, 65535);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0001);
        wait_drain();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the output register and sequencer fill and input transfers stop.
    task automatic test_backpressure();
        set_filter(1'b1, lpf4_pkg::MODE_BANDPASS, 6000, -4384, 30000);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 300;
        repeat (40) send_sample(pick_sample());
        wait_drain();
    endtask

    // Random samples under one idling pattern, re-programmed every block.
    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (4)
        begin
            random_setting();
            repeat (BLOCK_ITEMS) send_sample(pick_sample());
            wait_drain();
        end
    endtask

    initial
    begin
        mdl_enable = 1'b0;
        mdl_mode   = lpf4_pkg::MODE_LOWPASS;
        k_p = 0;
        k_f = 0;
        k_q = 0;
        prev_in = 0;
        st1 = 0;
        st2 = 0;
        st3 = 0;
        st4 = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bypass();
        test_taps();
        test_coef_extremes();
        test_backpressure();
        test_random_phase(0, 0);
        test_random_phase(68, 0);
        test_random_phase(0, 68);
        test_random_phase(10, 10);

        $display("covered: bypass, all taps, extreme coefficients, long output hold-off,");
        $display("random settings; %0d samples in (%0d bypassed), %0d checked, %0d clipped",
                 samples_sent, bypass_count, samples_checked, clip_count);
        if (fault_count == 0)
            $display("ladder_lowpass_filter_4pole_tb OK");
        else
            $display("ladder_lowpass_filter_4pole_tb NOT OK");
        $finish;
    end

endmodule
